### src/glos_pkg.sv
// Package with shared types and constants for the line-of-sight block.
package glos_pkg;

  localparam int unsigned MapSideDef    = 64;
  localparam int unsigned DoorSlotsDef  = 128;
  localparam int unsigned CoordShiftDef = 8;

  localparam int unsigned CoordW = 22;
  localparam int unsigned PosW   = 23;  // signed 15.8 coordinate after the shift
  localparam int unsigned AccW   = 32;  // intercept and running minor coordinate
  localparam logic signed [16:0] SlopeMax = 17'sd32767;

  typedef enum logic [1:0] {
    OP_QUERY      = 2'd0,
    OP_WRITE_TILE = 2'd1,
    OP_WRITE_DOOR = 2'd2,
    OP_UNUSED     = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_AXIS,
    ST_DIV,
    ST_SETUP,
    ST_ADDR,
    ST_READ,
    ST_DOOR,
    ST_CHECK,
    ST_DONE
  } state_e;

  // Control from the sequencer to the divider.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Status from the divider.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### src/glos_if.sv
// Valid/ready channel interfaces for query items and result words.
interface glos_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [21:0] start_x;
  logic [21:0] start_y;
  logic [21:0] end_x;
  logic [21:0] end_y;
  logic [5:0]  tile_col;
  logic [5:0]  tile_row;
  logic [7:0]  tile_code;
  logic [6:0]  door_slot;
  logic [15:0] door_open;
  modport source (output valid, operation, start_x, start_y, end_x, end_y, tile_col,
                  tile_row, tile_code, door_slot, door_open, input ready);
  modport sink (input valid, operation, start_x, start_y, end_x, end_y, tile_col,
                tile_row, tile_code, door_slot, door_open, output ready);
endinterface

interface glos_out_if;
  logic valid;
  logic ready;
  logic line_clear;
  modport source (output valid, line_clear, input ready);
  modport sink (input valid, line_clear, output ready);
endinterface

### src/glos_div.sv
// Restoring divider that gives the truncated, saturated slope one bit a cycle.
module glos_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  glos_pkg::div_ctrl_t     ctrl_i,
  input  logic signed [31:0]      num_i,
  input  logic [22:0]             den_i,
  output glos_pkg::div_stat_t     stat_o,
  output logic signed [16:0]      slope_o
);
  import glos_pkg::*;

  logic [31:0] quo_q, quo_d;
  logic [23:0] rem_q, rem_d;
  logic [22:0] den_q, den_d;
  logic        neg_q, neg_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [23:0] trial;
  logic [31:0] mag;

  assign mag = num_i[31] ? 32'(-num_i) : 32'(num_i);

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[22:0], quo_q[31]} - {1'b0, den_q};
    if (ctrl_i.start) begin
      quo_d  = mag;
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = num_i[31];
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[23]) begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[22:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  logic signed [16:0] sat;
  always_comb begin
    if (quo_q > 32'd32767) sat = SlopeMax;
    else sat = 17'(signed'({1'b0, quo_q[15:0]}));
    slope_o = neg_q ? -sat : sat;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
endmodule

### src/grid_line_of_sight.sv
// Top level of the tile-map line-of-sight block with its walk sequencer.
// Usage: items arrive on the in_ch channel (valid/ready). Operation 1 writes a
// tile code into the map, operation 2 writes a door open position, operation 0
// asks whether the line between two points crosses no blocking tile. Each item
// gives exactly one word on out_ch; line_clear is 1 only for a clear query.
// A write or an unused operation goes to the done state, which registers its word,
// and the block is ready again in the same cycle that the word turns valid. A query
// walks each axis whose start and end tiles differ: it picks the axis, runs the
// shared 32-step divider for the slope, does a set-up step, then for each tile
// crossed the address, map read, door read and check steps. An axis without a
// crossing only passes through the axis state. The divider and the one map read
// per tile set the rate. After reset the block sweeps the tile map to zero, one
// entry a cycle (4096 entries by default), with ready low. Door slots have valid
// bits cleared at once. The result sits in an output register; while the
// receiver stalls the block holds it, takes one more item and keeps that item's
// result in its final state until the register is free. Walking stops at the
// first blocking tile.
module grid_line_of_sight #(
  parameter int unsigned MAP_SIDE    = glos_pkg::MapSideDef,
  parameter int unsigned DOOR_SLOTS  = glos_pkg::DoorSlotsDef,
  parameter int unsigned COORD_SHIFT = glos_pkg::CoordShiftDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  glos_in_if.sink    in_ch,
  glos_out_if.source out_ch
);
  import glos_pkg::*;

  localparam int unsigned SideW = $clog2(MAP_SIDE);
  localparam int unsigned AddrW = 2 * SideW;
  localparam int unsigned Depth = 1 << AddrW;
  localparam int unsigned SlotW = (DOOR_SLOTS > 1) ? $clog2(DOOR_SLOTS) : 1;

  state_e state_q, state_d;

  // Memories.
  logic [7:0]  tile_mem [Depth];
  logic [15:0] door_mem [DOOR_SLOTS];
  logic [DOOR_SLOTS-1:0] door_vld_q, door_vld_d;
  logic [7:0]  tile_rd_q;
  logic [15:0] door_rd_q;
  logic        door_rv_q;

  // Query registers.
  logic signed [PosW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic        axis_q, axis_d;        // 0 walks x, 1 walks y
  logic signed [PosW-1:0] a_q, a_d, aend_q, aend_d;
  logic signed [AccW-1:0] bfrac_q, bfrac_d;
  logic signed [16:0] step_q, step_d;
  logic signed [AccW-1:0] b_q, b_d;
  logic        inmap_q, inmap_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [AddrW:0]   clr_q, clr_d;
  logic        res_valid_q, res_valid_d, res_q, res_d;
  logic        out_q, out_d;

  // Walk set-up values for the current axis.
  logic signed [PosW-1:0] ma1, ma2, mb1, mb2;
  assign ma1 = axis_q ? y1_q : x1_q;
  assign ma2 = axis_q ? y2_q : x2_q;
  assign mb1 = axis_q ? x1_q : y1_q;
  assign mb2 = axis_q ? x2_q : y2_q;

  logic signed [PosW-9:0] at1, at2;
  assign at1 = ma1[PosW-1:8];
  assign at2 = ma2[PosW-1:8];

  logic [22:0] span;
  assign span = (ma2 > ma1) ? 23'(ma2 - ma1) : 23'(ma1 - ma2);

  logic signed [31:0] num;
  assign num = 32'(mb2 - mb1) <<< 8;

  div_ctrl_t div_ctrl;
  div_stat_t div_stat;
  logic signed [16:0] slope;

  glos_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .num_i  (num),
    .den_i  (span),
    .stat_o (div_stat),
    .slope_o(slope)
  );

  // Partial step to the first crossing, then floor of bstep*partial/256.
  logic [8:0] partial;
  logic signed [26:0] prod;
  assign partial = (at2 > at1) ? (9'd256 - {1'b0, ma1[7:0]}) : {1'b0, ma1[7:0]};
  assign prod = 27'(step_q * $signed({1'b0, partial}));

  // Door check on the tile just read.
  logic [AccW-1:0] icpt;
  logic [15:0]     dpos;
  logic            blocks;
  logic signed [16:0] half;
  assign half = step_q / 17'sd2;
  assign icpt = AccW'(bfrac_q - AccW'(half));
  assign dpos = door_rv_q ? door_rd_q : 16'd0;
  always_comb begin
    if (!inmap_q) blocks = 1'b1;
    else if (tile_rd_q == 8'd0) blocks = 1'b0;
    else if (!tile_rd_q[7]) blocks = 1'b1;
    else blocks = icpt > {16'd0, dpos};
  end

  // Column and row of the visited tile.
  logic signed [AccW-1:0] colv, rowv;
  assign colv = axis_q ? b_q : AccW'(a_q);
  assign rowv = axis_q ? AccW'(a_q) : b_q;

  logic in_acc, out_acc;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  function automatic logic signed [1:0] axis_step();
    return (at2 > at1) ? 2'sd1 : -2'sd1;
  endfunction

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == (AddrW+1)'(Depth - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_acc && op_e'(in_ch.operation) == OP_QUERY) state_d = ST_AXIS;
        else if (in_acc) state_d = ST_DONE;
      end
      ST_AXIS: begin
        if (at1 == at2) state_d = axis_q ? ST_DONE : ST_AXIS;
        else state_d = ST_DIV;
      end
      ST_DIV:   if (div_stat.done) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_READ;
      ST_READ:  state_d = ST_DOOR;
      ST_DOOR:  state_d = ST_CHECK;
      ST_CHECK: begin
        if (blocks) state_d = ST_DONE;
        else if (a_q + PosW'(axis_step()) == aend_q) state_d = axis_q ? ST_DONE : ST_AXIS;
        else state_d = ST_ADDR;
      end
      ST_DONE: if (!res_valid_q || out_acc) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    axis_d      = axis_q;
    a_d         = a_q;
    aend_d      = aend_q;
    bfrac_d     = bfrac_q;
    step_d      = step_q;
    b_d         = b_q;
    inmap_d     = inmap_q;
    addr_d      = addr_q;
    clr_d       = clr_q;
    res_d       = res_q;
    res_valid_d = res_valid_q;
    out_d       = out_q;
    door_vld_d  = door_vld_q;
    div_ctrl.start = 1'b0;
    if (out_acc) res_valid_d = 1'b0;
    unique case (state_q)
      ST_CLEAR: clr_d = clr_q + 1'b1;
      ST_IDLE: begin
        axis_d = 1'b0;
        res_d  = 1'b0;
        if (in_acc && op_e'(in_ch.operation) == OP_WRITE_DOOR &&
            32'(in_ch.door_slot) < DOOR_SLOTS)
          door_vld_d[SlotW'(in_ch.door_slot)] = 1'b1;
      end
      ST_AXIS: begin
        if (at1 == at2) begin
          if (axis_q) res_d = 1'b1;
          axis_d = 1'b1;
        end else div_ctrl.start = 1'b1;
      end
      ST_DIV: step_d = slope;
      ST_SETUP: begin
        bfrac_d = AccW'(mb1) + AccW'(prod >>> 8);
        a_d     = PosW'(at1) + PosW'(axis_step());
        aend_d  = PosW'(at2) + PosW'(axis_step());
      end
      ST_ADDR: begin
        b_d     = bfrac_q >>> 8;
        bfrac_d = bfrac_q + AccW'(step_q);
      end
      ST_READ: begin
        inmap_d = (colv >= 0) && (colv < AccW'(MAP_SIDE)) &&
                  (rowv >= 0) && (rowv < AccW'(MAP_SIDE));
        addr_d  = {colv[SideW-1:0], rowv[SideW-1:0]};
      end
      ST_CHECK: begin
        a_d = a_q + PosW'(axis_step());
        if (!blocks && a_d == aend_q) begin
          if (axis_q) res_d = 1'b1;
          axis_d = 1'b1;
        end
      end
      ST_DONE: begin
        if (!res_valid_q || out_acc) begin
          res_valid_d = 1'b1;
          out_d       = res_q;
        end
      end
      default: ;
    endcase
  end

  // The map address formed in ST_READ is read at the end of that cycle; the
  // door table is read from the tile code at the end of ST_DOOR, so both are
  // settled in ST_CHECK.
  logic [AddrW-1:0] rd_addr;
  assign rd_addr = addr_d;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) tile_mem[clr_q[AddrW-1:0]] <= 8'd0;
    else if (in_acc && op_e'(in_ch.operation) == OP_WRITE_TILE &&
             32'(in_ch.tile_col) < MAP_SIDE && 32'(in_ch.tile_row) < MAP_SIDE)
      tile_mem[{SideW'(in_ch.tile_col), SideW'(in_ch.tile_row)}] <= in_ch.tile_code;
    tile_rd_q <= tile_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && op_e'(in_ch.operation) == OP_WRITE_DOOR &&
        32'(in_ch.door_slot) < DOOR_SLOTS)
      door_mem[SlotW'(in_ch.door_slot)] <= in_ch.door_open;
    door_rd_q <= door_mem[SlotW'(tile_rd_q[6:0])];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
      door_vld_q  <= '0;
      door_rv_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
      door_vld_q  <= door_vld_d;
      door_rv_q   <= (32'(tile_rd_q[6:0]) < DOOR_SLOTS) &&
                     door_vld_q[SlotW'(tile_rd_q[6:0])];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x1_q <= PosW'(in_ch.start_x >> COORD_SHIFT);
      y1_q <= PosW'(in_ch.start_y >> COORD_SHIFT);
      x2_q <= PosW'(in_ch.end_x >> COORD_SHIFT);
      y2_q <= PosW'(in_ch.end_y >> COORD_SHIFT);
    end
    axis_q  <= axis_d;
    a_q     <= a_d;
    aend_q  <= aend_d;
    bfrac_q <= bfrac_d;
    step_q  <= step_d;
    b_q     <= b_d;
    inmap_q <= inmap_d;
    addr_q  <= addr_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign in_ch.ready       = (state_q == ST_IDLE);
  assign out_ch.valid      = res_valid_q;
  assign out_ch.line_clear = out_q;
endmodule
